### sv/tdp_pkg.sv
// ----------------------------------------------------------------------------
// tdp_pkg: shared types and constants for the primality tester
// Holds the default datapath width, the candidate width and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tdp_pkg;

    // width of the candidate port
    localparam int CAND_W       = 32;
    // default datapath width
    localparam int NUM_BITS_DEF = 32;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture candidate, set divisor to two
        logic div_start;  // start a division n / d
        logic inc_div;    // move on to the next divisor
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic small_n;    // n is zero or one
        logic div_done;   // division has finished this cycle
        logic d_gt_quo;   // d > n / d, search is over
        logic rem_zero;   // d divides n
    } t_dp_status;

endpackage

### sv/tdp_divider.sv
// ----------------------------------------------------------------------------
// tdp_divider: restoring divider, one quotient bit per cycle
// When the division finishes, done pulses with quotient and remainder.
// The divisor must stay stable while the division runs.
// ----------------------------------------------------------------------------
module tdp_divider #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    // one restoring step
    always_comb begin
        trial  = {r_rem, r_quo[WIDTH-1]};
        diff   = trial - {1'b0, i_divisor};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = CNT_W'(WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[WIDTH]) begin
                n_rem = diff[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                n_rem = trial[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### sv/tdp_datapath.sv
// ----------------------------------------------------------------------------
// tdp_datapath: candidate and divisor registers around the shared divider
// Reports to the controller whether the search ends or a factor is found.
// ----------------------------------------------------------------------------
module tdp_datapath #(
    parameter int NUM_BITS = tdp_pkg::NUM_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tdp_pkg::CAND_W-1:0] i_candidate,
    input  tdp_pkg::t_dp_cmd           i_cmd,
    output tdp_pkg::t_dp_status        o_status
);
    import tdp_pkg::*;

    logic [NUM_BITS-1:0] r_n;
    logic [NUM_BITS-1:0] r_d;
    logic [NUM_BITS-1:0] cand_ext;
    logic [NUM_BITS-1:0] quo;
    logic [NUM_BITS-1:0] rem;
    logic                div_done;

    // candidate reduced or extended to the datapath width
    generate
        if (NUM_BITS > CAND_W) begin : g_ext
            assign cand_ext = {{(NUM_BITS - CAND_W){1'b0}}, i_candidate};
        end else if (NUM_BITS == CAND_W) begin : g_same
            assign cand_ext = i_candidate;
        end else begin : g_trunc
            assign cand_ext = i_candidate[NUM_BITS-1:0];
        end
    endgenerate

    // candidate and trial divisor
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= cand_ext;
            r_d <= NUM_BITS'(2);
        end else if (i_cmd.inc_div) begin
            r_d <= r_d + NUM_BITS'(1);
        end
    end

    tdp_divider #(
        .WIDTH (NUM_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_n),
        .i_divisor   (r_d),
        .o_done      (div_done),
        .o_quotient  (quo),
        .o_remainder (rem)
    );

    // status back to the controller
    always_comb begin
        o_status.small_n  = (r_n[NUM_BITS-1:1] == '0);
        o_status.div_done = div_done;
        o_status.d_gt_quo = (r_d > quo);
        o_status.rem_zero = (rem == '0);
    end

endmodule

### sv/tdp_ctrl.sv
// ----------------------------------------------------------------------------
// tdp_ctrl: sequencer for the trial-division search
// Steps through divisors, decides the verdict and drives the result strobe.
// ----------------------------------------------------------------------------
module tdp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tdp_pkg::t_dp_status i_status,
    output tdp_pkg::t_dp_cmd    o_cmd,
    output logic                o_valid,
    output logic                o_is_prime_flag
);
    import tdp_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_TEST  = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_valid, n_valid;
    logic       r_flag,  n_flag;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_flag  = r_flag;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TEST;
                end
            end
            S_TEST: begin
                if (i_status.small_n) begin
                    n_valid = 1'b1;
                    n_flag  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.d_gt_quo) begin
                    n_valid = 1'b1;
                    n_flag  = 1'b1;
                    n_state = S_IDLE;
                end else if (i_status.rem_zero) begin
                    n_valid = 1'b1;
                    n_flag  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.inc_div = 1'b1;
                    n_state       = S_TEST;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // result flag
    always_ff @(posedge i_clk) begin
        r_flag <= n_flag;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_is_prime_flag = r_flag;

endmodule

### sv/trial_division_primality_test.sv
// ----------------------------------------------------------------------------
// The verdict for 0 and 1 comes without a division; otherwise one division
// runs per trial divisor, for k divisors tried (k up to about sqrt(n)).
// Throughput: one candidate at a time; busy is high until the verdict is out,
// set by the single bit-serial divider shared by all divisors.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset (synchronous, active low) returns the sequencer to idle.
// ----------------------------------------------------------------------------
// trial_division_primality_test: top level
// Tests one unsigned candidate for primality by trial division.
// ----------------------------------------------------------------------------
module trial_division_primality_test #(
    parameter int NUM_BITS = tdp_pkg::NUM_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [tdp_pkg::CAND_W-1:0] i_candidate,
    output logic                       o_valid,
    output logic                       o_is_prime_flag
);
    import tdp_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer
    tdp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_status        (status),
        .o_cmd           (cmd),
        .o_valid         (o_valid),
        .o_is_prime_flag (o_is_prime_flag)
    );

    // registers and divider
    tdp_datapath #(
        .NUM_BITS (NUM_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_candidate (i_candidate),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

### tb/sv/trial_division_primality_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_primality_checker: verdict scoreboard for the primality tester
// Watches the candidate and result channels, works out the expected verdict
// for every accepted candidate, and compares each result strobe against the
// oldest verdict still waiting.
// ----------------------------------------------------------------------------
module trial_division_primality_checker #(
    parameter int NUM_BITS = tdp_pkg::NUM_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [tdp_pkg::CAND_W-1:0] i_candidate,
    input  logic                       i_valid,
    input  logic                       i_is_prime_flag,
    output int                         o_errors,
    output int                         o_pending
);

    import tdp_pkg::*;

    typedef struct {
        logic [CAND_W-1:0] candidate;
        logic              exp_flag;
    } t_verdict;

    t_verdict expected_verdicts[$];
    int       error_count   = 0;
    int       pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    // trial division on the low NUM_BITS bits, bound kept as d <= n / d
    function automatic logic prime_by_trial(input logic [CAND_W-1:0] cand);
        longint unsigned mask;
        longint unsigned n;
        longint unsigned d;
        mask = (NUM_BITS >= 64) ? '1 : ((64'd1 << NUM_BITS) - 64'd1);
        n    = longint'(cand) & mask;
        if (n <= 1)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        for (d = 2; d <= n / d; d++) begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // count a failure, report only the first few
    task automatic flag_mismatch(input string what);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // candidate transfers feed the store, result strobes drain it
    always @(posedge i_clk) begin : scoreboard
        t_verdict v;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                v.candidate = i_candidate;
                v.exp_flag  = prime_by_trial(i_candidate);
                expected_verdicts.push_back(v);
                pending_count++;
            end
            if (i_valid) begin
                if (expected_verdicts.size() == 0) begin
                    flag_mismatch($sformatf("result %0b with no candidate outstanding",
                                            i_is_prime_flag));
                end else begin
                    v = expected_verdicts.pop_front();
                    pending_count--;
                    if (i_is_prime_flag !== v.exp_flag)
                        flag_mismatch($sformatf("candidate %0d: expected %0b, got %0b",
                                                v.candidate, v.exp_flag, i_is_prime_flag));
                end
            end
        end
    end

endmodule

### tb/sv/tb_trial_division_primality_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trial_division_primality_test: testbench top for the primality tester
// Drives corner candidates and then random ones with random gaps, leaves
// checking to the scoreboard beside the block and gives the verdict.
// ----------------------------------------------------------------------------
module tb_trial_division_primality_test;

    import tdp_pkg::*;

    localparam int RANDOM_ITEMS = 78;
    // slowest item is a prime just under 2**24, about 4k trial divisors
    localparam int IDLE_LIMIT   = 600_000;
    localparam int DRAIN_CYCLES = 4 * (NUM_BITS_DEF + 3);

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic [CAND_W-1:0] i_candidate = '0;
    logic              busy;
    logic              o_valid;
    logic              o_is_prime_flag;

    int mismatches;
    int awaiting;
    int idle_cycles = 0;

    // zero, one, two, small primes and squares, wide patterns, costly primes
    logic [CAND_W-1:0] corner_values [0:21] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
        32'd97, 32'd121,
        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFE,
        32'hAAAA_AAAA, 32'h5555_5555,
        32'd65521, 32'd65537,
        32'd1052651,    // 1021 * 1031
        32'd16752649,   // 4093 squared
        32'd16777213    // largest prime below 2**24
    };

    trial_division_primality_test #(
        .NUM_BITS(NUM_BITS_DEF)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_candidate    (i_candidate),
        .o_valid        (o_valid),
        .o_is_prime_flag(o_is_prime_flag)
    );

    trial_division_primality_checker #(
        .NUM_BITS(NUM_BITS_DEF)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_candidate    (i_candidate),
        .i_valid        (o_valid),
        .i_is_prime_flag(o_is_prime_flag),
        .o_errors       (mismatches),
        .o_pending      (awaiting)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // present one candidate and hold it until the transfer
    task automatic send_candidate(input logic [CAND_W-1:0] value);
        start       <= 1'b1;
        i_candidate <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // mostly short gaps, now and then a long one
    task automatic idle_gap(input bit steady);
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = 0;
        if (!steady) begin
            if (r >= 90)
                n = $urandom_range(20, 150);
            else if (r >= 40)
                n = $urandom_range(1, 4);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // small values mostly, wide ones made cheap by a small factor
    function automatic logic [CAND_W-1:0] next_candidate();
        int unsigned factors [0:10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
        int unsigned r;
        int unsigned v;
        int unsigned p;
        r = $urandom_range(0, 99);
        if (r < 20)
            return CAND_W'($urandom_range(0, 300));
        if (r < 70)
            return CAND_W'($urandom_range(0, 16383));
        if (r < 80)
            return CAND_W'($urandom_range(0, 65535));
        v = $urandom;
        p = factors[$urandom_range(0, 10)];
        return CAND_W'(v - (v % p));
    endfunction

    // stimulus and verdict
    initial begin
        bit steady;
        steady = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        foreach (corner_values[k]) begin
            send_candidate(corner_values[k]);
            idle_gap(1'b0);
        end

        // hold off until every verdict is back
        start <= 1'b0;
        do @(posedge i_clk); while (awaiting != 0);

        // random candidates, with runs of back-to-back transfers
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 25 == 0)
                steady = ($urandom_range(0, 2) == 0);
            send_candidate(next_candidate());
            idle_gap(steady);
        end
        start <= 1'b0;

        // drain
        do @(posedge i_clk); while (awaiting != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && awaiting == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
sv/tdp_pkg.sv
sv/tdp_divider.sv
sv/tdp_datapath.sv
sv/tdp_ctrl.sv
sv/trial_division_primality_test.sv
tb/sv/trial_division_primality_checker.sv
tb/sv/tb_trial_division_primality_test.sv
